>>> hdl/assert_macros.svh
// Assertion helpers used by the back module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define KVH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("kvh assertion failed");

// When the condition holds, the consequence must hold in the next cycle.
`define KVH_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("kvh assertion failed");

`endif

>>> hdl/kvh_pkg.sv
`timescale 1ns / 1ps

package kvh_pkg;

    // Default sizes.
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_PROBES_DEF    = 128;
    localparam int FILTER_BITS_DEF   = 16384;
    localparam int KEY_BYTES_DEF     = 24;
    localparam int VALUE_BYTES_DEF   = 24;

    // Fixed port geometry.
    localparam int FIELD_BYTES = 24;
    localparam int FIELD_W     = FIELD_BYTES * 8;
    localparam int Q_DEPTH     = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_EXISTS = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ABSENT = 3'd1,
        ST_BLOOM  = 3'd2,
        ST_BADLEN = 3'd3,
        ST_PROBE  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CRC,
        FS_MOD,
        FS_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_CMP,
        BS_ACT,
        BS_DONE
    } t_back_state;

    // A classified request as it travels from the front to the back.
    typedef struct packed {
        t_op                op;
        logic               bad;
        logic [4:0]         klen;
        logic [FIELD_W-1:0] key;
        logic [4:0]         vlen;
        logic [FIELD_W-1:0] val;
        logic [31:0]        hash;
        logic [15:0]        bidx;
    } t_req;

    // One result transaction.
    typedef struct packed {
        t_status            status;
        logic               was_present;
        logic [4:0]         read_length;
        logic [FIELD_W-1:0] read_bytes;
        logic [12:0]        entries;
    } t_res;

    // Keep the first len bytes of a byte string, zero the rest.
    function automatic logic [FIELD_W-1:0] trim_bytes(input logic [FIELD_W-1:0] d,
                                                      input logic [4:0] len);
        logic [FIELD_W-1:0] r;
        r = '0;
        for (int i = 0; i < FIELD_BYTES; i++) begin
            if (5'(i) < len) begin
                r[i*8 +: 8] = d[i*8 +: 8];
            end
        end
        return r;
    endfunction

    // One byte of reflected CRC-32, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

>>> hdl/kvh_front.sv
`timescale 1ns / 1ps

module kvh_front #(
    parameter int KEY_BYTES   = kvh_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES = kvh_pkg::VALUE_BYTES_DEF,
    parameter int FILTER_BITS = kvh_pkg::FILTER_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_operation,
    input  logic [4:0]                  i_key_length,
    input  logic [kvh_pkg::FIELD_W-1:0] i_key,
    input  logic [4:0]                  i_value_length,
    input  logic [kvh_pkg::FIELD_W-1:0] i_value,
    output logic                        o_push,
    output kvh_pkg::t_req               o_req,
    input  logic                        i_full
);

    localparam int RW        = $clog2(FILTER_BITS) + 1;
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = 32 / MOD_BITS;

    kvh_pkg::t_front_state r_state, n_state;
    kvh_pkg::t_req         r_req;
    logic [31:0]           r_crc;
    logic [kvh_pkg::FIELD_W-1:0] r_shift;
    logic [4:0]            r_cnt;
    logic [RW-1:0]         r_rem;
    logic [2:0]            r_mcnt;

    logic        w_acc;
    logic        w_bad;
    logic        w_crc_last;
    logic        w_mod_last;
    logic [31:0] w_crc;
    logic [RW-1:0] w_rem;

    // Length check and accept.
    assign w_acc = i_valid && (r_state == kvh_pkg::FS_IDLE);
    assign w_bad = (i_key_length == 5'd0) || (i_key_length > 5'(KEY_BYTES)) ||
                   ((i_operation == kvh_pkg::OP_SET) &&
                    ((i_value_length == 5'd0) || (i_value_length > 5'(VALUE_BYTES))));

    // One key byte of CRC per cycle.
    assign w_crc      = kvh_pkg::crc_byte(r_crc, r_shift[7:0]);
    assign w_crc_last = (r_cnt == (r_req.klen - 5'd1));
    assign w_mod_last = (r_mcnt == 3'(MOD_STEPS - 1));

    // Bloom index: hash remainder, four hash bits per cycle, MSB first.
    always_comb begin
        logic [RW-1:0] rem;
        rem = r_rem;
        for (int k = 0; k < MOD_BITS; k++) begin
            rem = {rem[RW-2:0], r_crc[31-k]};
            if (rem >= RW'(FILTER_BITS)) begin
                rem = rem - RW'(FILTER_BITS);
            end
        end
        w_rem = rem;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvh_pkg::FS_IDLE: begin
                if (w_acc) begin
                    n_state = w_bad ? kvh_pkg::FS_PUSH : kvh_pkg::FS_CRC;
                end
            end
            kvh_pkg::FS_CRC: begin
                if (w_crc_last) begin
                    n_state = kvh_pkg::FS_MOD;
                end
            end
            kvh_pkg::FS_MOD: begin
                if (w_mod_last) begin
                    n_state = kvh_pkg::FS_PUSH;
                end
            end
            kvh_pkg::FS_PUSH: begin
                if (!i_full) begin
                    n_state = kvh_pkg::FS_IDLE;
                end
            end
            default: n_state = kvh_pkg::FS_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_stall = (r_state != kvh_pkg::FS_IDLE);
        o_push  = (r_state == kvh_pkg::FS_PUSH) && !i_full;
    end

    assign o_req = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvh_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kvh_pkg::FS_IDLE: begin
                if (w_acc) begin
                    r_req.op   <= kvh_pkg::t_op'(i_operation);
                    r_req.bad  <= w_bad;
                    r_req.klen <= i_key_length;
                    r_req.key  <= kvh_pkg::trim_bytes(i_key, i_key_length);
                    r_req.vlen <= i_value_length;
                    r_req.val  <= kvh_pkg::trim_bytes(i_value, i_value_length);
                    r_shift    <= kvh_pkg::trim_bytes(i_key, i_key_length);
                    r_crc      <= kvh_pkg::CRC_INIT;
                    r_cnt      <= 5'd0;
                end
            end
            kvh_pkg::FS_CRC: begin
                r_shift <= r_shift >> 8;
                r_cnt   <= r_cnt + 5'd1;
                if (w_crc_last) begin
                    r_crc      <= ~w_crc;
                    r_req.hash <= ~w_crc;
                    r_rem      <= '0;
                    r_mcnt     <= 3'd0;
                end else begin
                    r_crc <= w_crc;
                end
            end
            kvh_pkg::FS_MOD: begin
                r_rem  <= w_rem;
                r_crc  <= r_crc << MOD_BITS;
                r_mcnt <= r_mcnt + 3'd1;
                if (w_mod_last) begin
                    r_req.bidx <= 16'(w_rem);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hdl/kvh_queue.sv
`timescale 1ns / 1ps

module kvh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kvh_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output kvh_pkg::t_req o_req,
    output logic          o_empty
);

    localparam int DEPTH = kvh_pkg::Q_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    kvh_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_mem[r_rd];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> hdl/kvh_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kvh_back #(
    parameter int TABLE_ENTRIES = kvh_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = kvh_pkg::MAX_PROBES_DEF,
    parameter int FILTER_BITS   = kvh_pkg::FILTER_BITS_DEF,
    parameter int KEY_BYTES     = kvh_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES   = kvh_pkg::VALUE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  kvh_pkg::t_req i_req,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output kvh_pkg::t_res o_res
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int BW    = $clog2(FILTER_BITS);
    localparam int PW    = $clog2(MAX_PROBES + 1);
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int CLR_N = (TABLE_ENTRIES > FILTER_BITS) ? TABLE_ENTRIES : FILTER_BITS;
    localparam int LW    = $clog2(CLR_N);
    localparam int KW    = KEY_BYTES * 8;
    localparam int VW    = VALUE_BYTES * 8;
    localparam int ENT_W = 32 + 5 + KW + 5 + VW;

    // Slot entry layout: {hash, key length, key, value length, value}.
    localparam int E_VAL  = 0;
    localparam int E_VLEN = VW;
    localparam int E_KEY  = VW + 5;
    localparam int E_KLEN = VW + 5 + KW;
    localparam int E_HASH = VW + 10 + KW;

    kvh_pkg::t_back_state r_state, n_state;
    kvh_pkg::t_req        r_req;
    kvh_pkg::t_res        r_res;
    kvh_pkg::t_res        r_out;
    logic                 r_out_valid;
    logic [AW-1:0]        r_idx;
    logic [PW-1:0]        r_probe;
    logic                 r_hit;
    logic [LW-1:0]        r_clr;
    logic [CW-1:0]        r_count;

    // Memories.
    logic                 m_occ   [TABLE_ENTRIES];
    logic                 m_bloom [FILTER_BITS];
    logic [ENT_W-1:0]     m_ent   [TABLE_ENTRIES];
    logic                 r_occ_rd;
    logic                 r_bloom_rd;
    logic [ENT_W-1:0]     r_ent_rd;

    logic                 w_occ_we, w_occ_d;
    logic [AW-1:0]        w_occ_addr;
    logic                 w_bloom_we;
    logic [BW-1:0]        w_bloom_addr;
    logic                 w_ent_we;
    logic [ENT_W-1:0]     w_ent_d;

    logic w_clr_last;
    logic w_match;
    logic w_bloom_stop;
    logic w_probe_last;
    logic w_out_free;
    logic w_load;

    assign w_clr_last   = (r_clr == LW'(CLR_N - 1));
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_load       = (r_state == kvh_pkg::BS_DONE) && w_out_free;
    assign w_probe_last = (r_probe == PW'(MAX_PROBES - 1));

    // Slot compare: stored hash, key length and key bytes.
    assign w_match = (r_ent_rd[E_HASH +: 32] == r_req.hash) &&
                     (r_ent_rd[E_KLEN +: 5] == r_req.klen) &&
                     (r_ent_rd[E_KEY +: KW] == r_req.key[KW-1:0]);

    assign w_bloom_stop = ((r_req.op == kvh_pkg::OP_GET) ||
                           (r_req.op == kvh_pkg::OP_EXISTS)) && !r_bloom_rd;

    assign w_ent_d = {r_req.hash, r_req.klen, r_req.key[KW-1:0],
                      r_req.vlen, r_req.val[VW-1:0]};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvh_pkg::BS_CLEAR: begin
                if (w_clr_last) begin
                    n_state = kvh_pkg::BS_IDLE;
                end
            end
            kvh_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    n_state = i_req.bad ? kvh_pkg::BS_DONE : kvh_pkg::BS_READ;
                end
            end
            kvh_pkg::BS_READ: n_state = kvh_pkg::BS_CMP;
            kvh_pkg::BS_CMP: begin
                priority if (w_bloom_stop) begin
                    n_state = kvh_pkg::BS_DONE;
                end else if (!r_occ_rd || w_match) begin
                    n_state = kvh_pkg::BS_ACT;
                end else if (w_probe_last) begin
                    n_state = kvh_pkg::BS_DONE;
                end else begin
                    n_state = kvh_pkg::BS_READ;
                end
            end
            kvh_pkg::BS_ACT: n_state = kvh_pkg::BS_DONE;
            kvh_pkg::BS_DONE: begin
                if (w_out_free) begin
                    n_state = kvh_pkg::BS_IDLE;
                end
            end
            default: n_state = kvh_pkg::BS_IDLE;
        endcase
    end

    // Memory write controls and queue pop.
    always_comb begin
        o_pop        = 1'b0;
        w_occ_we     = 1'b0;
        w_occ_d      = 1'b0;
        w_occ_addr   = r_idx;
        w_bloom_we   = 1'b0;
        w_bloom_addr = r_req.bidx[BW-1:0];
        w_ent_we     = 1'b0;
        unique case (r_state)
            kvh_pkg::BS_CLEAR: begin
                w_occ_we     = (r_clr < LW'(TABLE_ENTRIES)) || (CLR_N == TABLE_ENTRIES);
                w_occ_addr   = r_clr[AW-1:0];
                w_bloom_we   = (r_clr < LW'(FILTER_BITS)) || (CLR_N == FILTER_BITS);
                w_bloom_addr = r_clr[BW-1:0];
            end
            kvh_pkg::BS_IDLE: o_pop = !i_empty;
            kvh_pkg::BS_ACT: begin
                unique case (r_req.op)
                    kvh_pkg::OP_SET: begin
                        w_ent_we   = 1'b1;
                        w_occ_we   = !r_hit;
                        w_occ_d    = 1'b1;
                        w_bloom_we = 1'b1;
                    end
                    kvh_pkg::OP_DELETE: begin
                        w_occ_we = r_hit;
                        w_occ_d  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Occupied marks.
    always_ff @(posedge i_clk) begin
        if (w_occ_we) begin
            m_occ[w_occ_addr] <= w_occ_d;
        end
        r_occ_rd <= m_occ[r_idx];
    end

    // Bloom marks; a write only ever sets a bit outside the clearing pass.
    always_ff @(posedge i_clk) begin
        if (w_bloom_we) begin
            m_bloom[w_bloom_addr] <= (r_state != kvh_pkg::BS_CLEAR);
        end
        r_bloom_rd <= m_bloom[r_req.bidx[BW-1:0]];
    end

    // Slot entries.
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            m_ent[r_idx] <= w_ent_d;
        end
        r_ent_rd <= m_ent[r_idx];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kvh_pkg::BS_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == kvh_pkg::BS_CLEAR) begin
                r_clr <= r_clr + LW'(1);
            end
            if ((r_state == kvh_pkg::BS_ACT) && (r_req.op == kvh_pkg::OP_SET) && !r_hit) begin
                r_count <= r_count + CW'(1);
            end else if ((r_state == kvh_pkg::BS_ACT) && (r_req.op == kvh_pkg::OP_DELETE) &&
                         r_hit && (r_count != '0)) begin
                r_count <= r_count - CW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            kvh_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    r_req   <= i_req;
                    r_idx   <= i_req.hash[AW-1:0] & AW'(TABLE_ENTRIES - 1);
                    r_probe <= '0;
                    r_hit   <= 1'b0;
                    r_res   <= '{status: (i_req.bad ? kvh_pkg::ST_BADLEN : kvh_pkg::ST_OK),
                                 was_present: 1'b0, read_length: 5'd0,
                                 read_bytes: '0, entries: 13'd0};
                end
            end
            kvh_pkg::BS_CMP: begin
                r_hit <= r_occ_rd && w_match;
                if (w_bloom_stop) begin
                    r_res.status <= kvh_pkg::ST_BLOOM;
                end else if (r_occ_rd && !w_match) begin
                    r_res.status <= kvh_pkg::ST_PROBE;
                    r_idx        <= (r_idx + AW'(1)) & AW'(TABLE_ENTRIES - 1);
                    r_probe      <= r_probe + PW'(1);
                end
            end
            kvh_pkg::BS_ACT: begin
                r_res.was_present <= r_hit;
                r_res.status      <= (r_hit || (r_req.op == kvh_pkg::OP_SET)) ?
                                     kvh_pkg::ST_OK : kvh_pkg::ST_ABSENT;
                if ((r_req.op == kvh_pkg::OP_GET) && r_hit) begin
                    r_res.read_length <= r_ent_rd[E_VLEN +: 5];
                    r_res.read_bytes  <= kvh_pkg::FIELD_W'(r_ent_rd[E_VAL +: VW]);
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out <= '{status: r_res.status, was_present: r_res.was_present,
                       read_length: r_res.read_length, read_bytes: r_res.read_bytes,
                       entries: 13'(r_count)};
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `KVH_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_ENTRIES))
    `KVH_ASSERT(a_no_pop_in_clear, i_clk, i_rst_n, (r_state == kvh_pkg::BS_CLEAR) |-> !o_pop)
    `KVH_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, w_load, r_out_valid && (r_state == kvh_pkg::BS_IDLE))

endmodule

>>> hdl/kv_hash_table_engine.sv
`timescale 1ns / 1ps

// Key-value engine on an open-addressing hash table with linear probing. Each
// request transaction is a set, get, exists or delete on a key of 1 to KEY_BYTES
// bytes, and each gives one result transaction. The front computes the reflected
// CRC-32 of the key one byte per cycle and then the bloom index from the hash; a
// request with a bad length skips both. The back probes each slot with a read
// state and a compare state (registered memory reads), plus idle, act and done
// states of bookkeeping; a two-entry queue lets the front hash the next request
// while the back probes. After reset the back runs a clearing pass of
// max(TABLE_ENTRIES, FILTER_BITS) addresses over the occupied and bloom
// memories before it serves the first request; requests queue meanwhile.
module kv_hash_table_engine #(
    parameter int TABLE_ENTRIES = kvh_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_PROBES    = kvh_pkg::MAX_PROBES_DEF,
    parameter int FILTER_BITS   = kvh_pkg::FILTER_BITS_DEF,
    parameter int KEY_BYTES     = kvh_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BYTES   = kvh_pkg::VALUE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [4:0]  i_key_length,
    input  logic [63:0] i_key_bytes_0_7,
    input  logic [63:0] i_key_bytes_8_15,
    input  logic [63:0] i_key_bytes_16_23,
    input  logic [4:0]  i_value_length,
    input  logic [63:0] i_value_bytes_0_7,
    input  logic [63:0] i_value_bytes_8_15,
    input  logic [63:0] i_value_bytes_16_23,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_was_present,
    output logic [4:0]  o_read_length,
    output logic [63:0] o_read_bytes_0_7,
    output logic [63:0] o_read_bytes_8_15,
    output logic [63:0] o_read_bytes_16_23,
    output logic [12:0] o_entries_stored
);

    kvh_pkg::t_req w_push_req, w_pop_req;
    kvh_pkg::t_res w_res;
    logic          w_push, w_full, w_pop, w_empty;

    kvh_front #(
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BYTES (VALUE_BYTES),
        .FILTER_BITS (FILTER_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_key_length   (i_key_length),
        .i_key          ({i_key_bytes_16_23, i_key_bytes_8_15, i_key_bytes_0_7}),
        .i_value_length (i_value_length),
        .i_value        ({i_value_bytes_16_23, i_value_bytes_8_15, i_value_bytes_0_7}),
        .o_push         (w_push),
        .o_req          (w_push_req),
        .i_full         (w_full)
    );

    kvh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_req   (w_pop_req),
        .o_empty (w_empty)
    );

    kvh_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_PROBES    (MAX_PROBES),
        .FILTER_BITS   (FILTER_BITS),
        .KEY_BYTES     (KEY_BYTES),
        .VALUE_BYTES   (VALUE_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_req   (w_pop_req),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_res)
    );

    // Result fields.
    assign o_status           = w_res.status;
    assign o_was_present      = w_res.was_present;
    assign o_read_length      = w_res.read_length;
    assign o_read_bytes_0_7   = w_res.read_bytes[63:0];
    assign o_read_bytes_8_15  = w_res.read_bytes[127:64];
    assign o_read_bytes_16_23 = w_res.read_bytes[191:128];
    assign o_entries_stored   = w_res.entries;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS       = 4096;
    localparam int PROBE_LIMIT = 128;
    localparam int FILTER_SIZE = 16384;
    localparam int MAX_LEN     = 24;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int POOL_SIZE   = 48;

    typedef struct {
        kvh_pkg::t_op op;
        logic [4:0]   klen;
        logic [191:0] key;
        logic [4:0]   vlen;
        logic [191:0] val;
        bit           drain;
    } t_request;

    typedef struct {
        kvh_pkg::t_status status;
        logic             present;
        logic [4:0]       rlen;
        logic [191:0]     rbytes;
        logic [12:0]      entries;
    } t_reply;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  in_op;
    logic [4:0]  in_klen;
    logic [63:0] in_k0, in_k1, in_k2;
    logic [4:0]  in_vlen;
    logic [63:0] in_v0, in_v1, in_v2;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  out_status;
    logic        out_present;
    logic [4:0]  out_rlen;
    logic [63:0] out_r0, out_r1, out_r2;
    logic [12:0] out_entries;

    // Shadow copy of the table.
    bit           shadow_used [SLOTS];
    logic [31:0]  shadow_hash [SLOTS];
    logic [4:0]   shadow_klen [SLOTS];
    logic [191:0] shadow_key  [SLOTS];
    logic [4:0]   shadow_vlen [SLOTS];
    logic [191:0] shadow_val  [SLOTS];
    bit           shadow_bloom[FILTER_SIZE];
    int unsigned  shadow_count;

    t_request     pending_requests[$];
    t_reply       expected_replies[$];
    int unsigned  error_count;
    int unsigned  cycle_count;
    bit           quiet_phase;
    int unsigned  send_gap;
    int unsigned  recv_gap;
    logic [191:0] key_pool [POOL_SIZE];
    logic [4:0]   klen_pool[POOL_SIZE];

    kv_hash_table_engine dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (in_valid),
        .o_stall            (out_stall),
        .i_operation        (in_op),
        .i_key_length       (in_klen),
        .i_key_bytes_0_7    (in_k0),
        .i_key_bytes_8_15   (in_k1),
        .i_key_bytes_16_23  (in_k2),
        .i_value_length     (in_vlen),
        .i_value_bytes_0_7  (in_v0),
        .i_value_bytes_8_15 (in_v1),
        .i_value_bytes_16_23(in_v2),
        .o_valid            (out_valid),
        .i_stall            (in_stall),
        .o_status           (out_status),
        .o_was_present      (out_present),
        .o_read_length      (out_rlen),
        .o_read_bytes_0_7   (out_r0),
        .o_read_bytes_8_15  (out_r1),
        .o_read_bytes_16_23 (out_r2),
        .o_entries_stored   (out_entries)
    );

    always begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Zero every byte at or past the given length.
    function automatic logic [191:0] keep_bytes(input logic [191:0] d, input logic [4:0] len);
        logic [191:0] r;
        r = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            if (i < len) begin
                r[i*8 +: 8] = d[i*8 +: 8];
            end
        end
        return r;
    endfunction

    // Reflected CRC-32 over the first len bytes.
    function automatic logic [31:0] key_crc(input logic [191:0] k, input logic [4:0] len);
        logic [31:0] c;
        c = 32'hFFFFFFFF;
        for (int i = 0; i < MAX_LEN; i++) begin
            if (i < len) begin
                c = c ^ {24'd0, k[i*8 +: 8]};
                for (int b = 0; b < 8; b++) begin
                    c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
                end
            end
        end
        return ~c;
    endfunction

    // Apply one request to the shadow table and return the reply it should give.
    function automatic t_reply apply_request(input t_request rq);
        t_reply       rp;
        logic [191:0] k;
        logic [31:0]  h;
        int unsigned  idx;
        int unsigned  bi;
        bit           hit;
        bit           found;
        rp = '{kvh_pkg::ST_OK, 1'b0, 5'd0, 192'd0, 13'd0};
        k = keep_bytes(rq.key, rq.klen);
        hit = 1'b0;
        found = 1'b0;
        if (rq.klen == 0 || rq.klen > MAX_LEN ||
            (rq.op == kvh_pkg::OP_SET && (rq.vlen == 0 || rq.vlen > MAX_LEN))) begin
            rp.status = kvh_pkg::ST_BADLEN;
        end else begin
            h = key_crc(k, rq.klen);
            bi = h % FILTER_SIZE;
            idx = h & (SLOTS - 1);
            if ((rq.op == kvh_pkg::OP_GET || rq.op == kvh_pkg::OP_EXISTS) &&
                !shadow_bloom[bi]) begin
                rp.status = kvh_pkg::ST_BLOOM;
            end else begin
                // Linear probe until an empty slot, a hit, or the limit.
                for (int n = 0; n < PROBE_LIMIT && !found; n++) begin
                    if (!shadow_used[idx]) begin
                        found = 1'b1;
                    end else if (shadow_hash[idx] == h && shadow_klen[idx] == rq.klen &&
                                 shadow_key[idx] == k) begin
                        found = 1'b1;
                        hit = 1'b1;
                    end else begin
                        idx = (idx + 1) & (SLOTS - 1);
                    end
                end
                if (!found) begin
                    rp.status = kvh_pkg::ST_PROBE;
                end else begin
                    case (rq.op)
                        kvh_pkg::OP_SET: begin
                            shadow_hash[idx] = h;
                            shadow_klen[idx] = rq.klen;
                            shadow_key[idx]  = k;
                            shadow_vlen[idx] = rq.vlen;
                            shadow_val[idx]  = keep_bytes(rq.val, rq.vlen);
                            if (!hit) begin
                                shadow_used[idx] = 1'b1;
                                shadow_count++;
                            end
                            shadow_bloom[bi] = 1'b1;
                        end
                        kvh_pkg::OP_GET: begin
                            if (!hit) begin
                                rp.status = kvh_pkg::ST_ABSENT;
                            end else begin
                                rp.rlen   = shadow_vlen[idx];
                                rp.rbytes = shadow_val[idx];
                            end
                        end
                        kvh_pkg::OP_EXISTS: begin
                            if (!hit) begin
                                rp.status = kvh_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            if (!hit) begin
                                rp.status = kvh_pkg::ST_ABSENT;
                            end else begin
                                shadow_used[idx] = 1'b0;
                                if (shadow_count > 0) begin
                                    shadow_count--;
                                end
                            end
                        end
                    endcase
                    rp.present = hit;
                end
            end
        end
        rp.entries = shadow_count[12:0];
        return rp;
    endfunction

    function automatic logic [191:0] random_bytes();
        return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic queue_request(input kvh_pkg::t_op op, input logic [4:0] klen,
                                 input logic [191:0] key, input logic [4:0] vlen,
                                 input logic [191:0] val);
        t_request rq;
        rq = '{op, klen, key, vlen, val, 1'b0};
        pending_requests.push_back(rq);
    endtask

    // A marker that makes the driver hold off until all replies are back.
    task automatic queue_drain();
        t_request rq;
        rq = '{kvh_pkg::OP_GET, 5'd0, 192'd0, 5'd0, 192'd0, 1'b1};
        pending_requests.push_back(rq);
    endtask

    task automatic report_mismatch(input string what, input logic [191:0] got,
                                   input logic [191:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Request driver.
    always @(posedge clk) begin
        t_request rq;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_op    <= '0;
            in_klen  <= '0;
            {in_k2, in_k1, in_k0} <= '0;
            in_vlen  <= '0;
            {in_v2, in_v1, in_v0} <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && !out_stall) begin
                rq.op = kvh_pkg::t_op'(in_op);
                rq.klen = in_klen;
                rq.key = {in_k2, in_k1, in_k0};
                rq.vlen = in_vlen;
                rq.val = {in_v2, in_v1, in_v0};
                expected_replies.push_back(apply_request(rq));
            end
            if (!in_valid || !out_stall) begin
                if (pending_requests.size() > 0 && pending_requests[0].drain) begin
                    in_valid <= 1'b0;
                    if (expected_replies.size() == 0 && !(in_valid && !out_stall)) begin
                        void'(pending_requests.pop_front());
                    end
                end else if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_requests.size() > 0 &&
                             (quiet_phase || $urandom_range(0, 9) != 0)) begin
                    rq = pending_requests.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= rq.op;
                    in_klen  <= rq.klen;
                    {in_k2, in_k1, in_k0} <= rq.key;
                    in_vlen  <= rq.vlen;
                    {in_v2, in_v1, in_v0} <= rq.val;
                end else begin
                    in_valid <= 1'b0;
                    if (!quiet_phase && pending_requests.size() > 0) begin
                        send_gap <= $urandom_range(1, 13) - 1;
                    end
                end
            end
        end
    end

    // Reply monitor with random back-pressure.
    always @(posedge clk) begin
        t_reply want;
        if (!rst_n) begin
            in_stall  <= 1'b0;
            recv_gap  <= 0;
        end else begin
            if (out_valid && !in_stall) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected reply", 192'd0, 192'd0);
                end else begin
                    want = expected_replies.pop_front();
                    if (out_status !== want.status)
                        report_mismatch("status", out_status, want.status);
                    if (out_present !== want.present)
                        report_mismatch("was_present", out_present, want.present);
                    if (out_rlen !== want.rlen)
                        report_mismatch("read_length", out_rlen, want.rlen);
                    if ({out_r2, out_r1, out_r0} !== want.rbytes)
                        report_mismatch("read_bytes", {out_r2, out_r1, out_r0}, want.rbytes);
                    if (out_entries !== want.entries)
                        report_mismatch("entries_stored", out_entries, want.entries);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                in_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(1, 13) - 1;
                in_stall <= 1'b1;
            end else begin
                in_stall <= 1'b0;
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [191:0] k;
        logic [191:0] v;
        logic [191:0] chain[$];
        int           pick;
        int           roll;
        int           seen;
        kvh_pkg::t_op op;
        logic [4:0]   klen;
        logic [4:0]   vlen;
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i]  = random_bytes();
            klen_pool[i] = (i < 4) ? ((i % 2) ? 5'd1 : 5'd24) : 5'($urandom_range(1, 24));
        end

        // Directed: length extremes, every operation, ignored bytes, bloom stop,
        // overwrite, delete of a missing key.
        k = {192{1'b1}};
        queue_request(kvh_pkg::OP_GET, 5'd24, k, 5'd0, '0);
        queue_request(kvh_pkg::OP_SET, 5'd24, k, 5'd24, {192{1'b1}});
        queue_request(kvh_pkg::OP_GET, 5'd24, k, 5'd0, '0);
        queue_request(kvh_pkg::OP_SET, 5'd24, k, 5'd1, random_bytes());
        queue_request(kvh_pkg::OP_GET, 5'd24, k, 5'd0, random_bytes());
        queue_request(kvh_pkg::OP_EXISTS, 5'd24, k, 5'd0, '0);
        queue_request(kvh_pkg::OP_SET, 5'd1, 192'd0, 5'd24, random_bytes());
        queue_request(kvh_pkg::OP_GET, 5'd1, {{184{1'b1}}, 8'd0}, 5'd0, '0);
        queue_request(kvh_pkg::OP_EXISTS, 5'd2, 192'd0, 5'd0, '0);
        queue_request(kvh_pkg::OP_DELETE, 5'd1, 192'd0, 5'd0, '0);
        queue_request(kvh_pkg::OP_GET, 5'd1, 192'd0, 5'd0, '0);
        queue_request(kvh_pkg::OP_DELETE, 5'd1, 192'd0, 5'd0, '0);
        queue_request(kvh_pkg::OP_DELETE, 5'd7, random_bytes(), 5'd0, '0);
        queue_request(kvh_pkg::OP_SET, 5'd0, k, 5'd4, k);
        queue_request(kvh_pkg::OP_GET, 5'd25, k, 5'd4, k);
        queue_request(kvh_pkg::OP_EXISTS, 5'd31, k, 5'd4, k);
        queue_request(kvh_pkg::OP_DELETE, 5'd0, k, 5'd4, k);
        queue_request(kvh_pkg::OP_SET, 5'd5, k, 5'd0, k);
        queue_request(kvh_pkg::OP_SET, 5'd5, k, 5'd25, k);
        queue_request(kvh_pkg::OP_SET, 5'd5, k, 5'd31, k);
        queue_request(kvh_pkg::OP_SET, 5'd12, random_bytes(), 5'd12, random_bytes());
        queue_request(kvh_pkg::OP_DELETE, 5'd24, k, 5'd0, '0);
        queue_request(kvh_pkg::OP_EXISTS, 5'd24, k, 5'd0, '0);
        queue_drain();

        // Probe limit: fill one chain with keys sharing a home slot.
        seen = 0;
        for (int i = 0; seen <= PROBE_LIMIT; i++) begin
            k = {168'd0, 24'(i)};
            if ((key_crc(k, 5'd3) & (SLOTS - 1)) == 12'h5A5) begin
                chain.push_back(k);
                seen++;
            end
        end
        foreach (chain[i]) begin
            queue_request(kvh_pkg::OP_SET, 5'd3, chain[i], 5'd8, random_bytes());
        end
        queue_request(kvh_pkg::OP_GET, 5'd3, chain[PROBE_LIMIT], 5'd0, '0);
        queue_request(kvh_pkg::OP_DELETE, 5'd3, chain[0], 5'd0, '0);
        queue_request(kvh_pkg::OP_GET, 5'd3, chain[1], 5'd0, '0);
        queue_request(kvh_pkg::OP_SET, 5'd3, chain[1], 5'd2, random_bytes());
        queue_request(kvh_pkg::OP_GET, 5'd3, chain[1], 5'd0, '0);

        // Random traffic, mostly on a small key pool so keys collide and hit.
        for (int n = 0; n < 350; n++) begin
            if (n == 175) begin
                queue_drain();
            end
            roll = $urandom_range(0, 99);
            op = kvh_pkg::t_op'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 35) begin
                op = kvh_pkg::OP_SET;
            end
            pick = $urandom_range(0, POOL_SIZE - 1);
            k = key_pool[pick];
            klen = klen_pool[pick];
            vlen = 5'($urandom_range(1, 24));
            v = random_bytes();
            if (roll < 50) begin
                // Same key bytes, fresh garbage past the key length.
                k = keep_bytes(k, klen) | (random_bytes() & ~keep_bytes({192{1'b1}}, klen));
            end else if (roll < 60) begin
                klen = 5'($urandom_range(0, 31));
                vlen = 5'($urandom_range(0, 31));
            end else if (roll < 68) begin
                k = random_bytes();
                klen = 5'($urandom_range(1, 24));
            end
            queue_request(op, klen, k, vlen, v);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 60) begin
            @(posedge clk);
        end
        quiet_phase = 1'b1;
    end

    // End of run once everything has drained.
    initial begin
        @(posedge rst_n);
        while (pending_requests.size() > 0 || in_valid || expected_replies.size() > 0) begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/kvh_pkg.sv
hdl/kvh_front.sv
hdl/kvh_queue.sv
hdl/kvh_back.sv
hdl/kv_hash_table_engine.sv
test/tb_top.sv
